@@ src/key_whitelist_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the key whitelist table
// Shared concurrent assertion forms, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef KEY_WHITELIST_TABLE_TOP_MACROS_SVH
`define KEY_WHITELIST_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define KWT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("kwt assertion failed");

// next-cycle implication, disabled during reset
`define KWT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("kwt assertion failed");

`endif

@@ src/kwt_pkg.sv @@
// ----------------------------------------------------------------------------
// kwt_pkg
// Types, codes and sizes shared by the key whitelist table modules.
// ----------------------------------------------------------------------------
package kwt_pkg;

    localparam int CAPACITY      = 32;
    localparam int KEY_W         = 64;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 6;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_DELETE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_SHIFT,
        BK_DONE
    } back_state_t;

endpackage

@@ src/kwt_ram.sv @@
// ----------------------------------------------------------------------------
// kwt_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ src/kwt_front.sv @@
// ----------------------------------------------------------------------------
// kwt_front
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module kwt_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [kwt_pkg::CMD_W-1:0]  s_command,
    input  logic [kwt_pkg::KEY_W-1:0]  s_key,
    output logic                       q_valid,
    output kwt_pkg::req_t              q_req,
    input  logic                       q_pop
);
    import kwt_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    req_t       req_dec;
    logic       push;

    // unused code 3 runs as a lookup
    always_comb begin
        req_dec.key = s_key;
        unique case (s_command)
            CMD_ADD:    req_dec.op = OP_ADD;
            CMD_DELETE: req_dec.op = OP_DELETE;
            default:    req_dec.op = OP_LOOKUP;
        endcase
    end

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_req   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= req_dec;
        end
    end

endmodule

@@ src/kwt_back.sv @@
// ----------------------------------------------------------------------------
// kwt_back
// Executes one request at a time: walks the key RAM for a match, appends on
// add, shifts later entries down on delete, and registers the result.
// ----------------------------------------------------------------------------
module kwt_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  kwt_pkg::req_t                      q_req,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kwt_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_present,
    output logic [kwt_pkg::ENTRY_COUNT_W-1:0]  m_entry_count
);
    import kwt_pkg::*;

    back_state_t                state_reg, state_next;
    req_t                       cur_reg, cur_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic [CNT_W-1:0]           pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic                       present_reg, present_next;
    logic                       m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]        m_status_reg, m_status_next;
    logic                       m_present_reg, m_present_next;
    logic [ENTRY_COUNT_W-1:0]   m_count_reg, m_count_next;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [KEY_W-1:0]           ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [KEY_W-1:0]           ram_rdata;

    logic                       match;
    logic                       more;
    logic                       finish;
    logic                       finish_hit;
    logic                       out_free;
    logic [CNT_W-1:0]           shift_dst;

    kwt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read data arrives the cycle after its address; pend_* tracks the slot in flight
    assign match     = pend_reg && (ram_rdata == cur_reg.key);
    assign more      = (idx_reg < count_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign shift_dst = pend_idx_reg - CNT_W'(1);

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        present_next   = present_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_present_next = m_present_reg;
        m_count_next   = m_count_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_wdata      = cur_reg.key;
        ram_raddr      = idx_reg[ADDR_W-1:0];
        finish         = 1'b0;
        finish_hit     = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cur_next   = q_req;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                if (match) begin
                    if (cur_reg.op == OP_DELETE) begin
                        present_next = 1'b1;
                        idx_next     = pend_idx_reg + CNT_W'(1);
                        pend_next    = 1'b0;
                        state_next   = BK_SHIFT;
                    end else begin
                        finish     = 1'b1;
                        finish_hit = 1'b1;
                    end
                end else if (!pend_reg && !more) begin
                    finish = 1'b1;
                end else begin
                    pend_next     = more;
                    pend_idx_next = idx_reg;
                    if (more) begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            BK_SHIFT: begin
                // slot i takes slot i+1; the stale top slot falls outside the count
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (!pend_reg && !more) begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = BK_DONE;
                end else begin
                    pend_next     = more;
                    pend_idx_next = idx_reg;
                    if (more) begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_present_next = present_reg;
                    m_count_next   = ENTRY_COUNT_W'(count_reg);
                    state_next     = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase

        if (finish) begin
            present_next = finish_hit;
            state_next   = BK_DONE;
            case (cur_reg.op)
                OP_ADD: begin
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        ram_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_OK;
                    end else begin
                        status_next = ST_FULL;
                    end
                end
                OP_DELETE: status_next = ST_ABSENT;
                default:   status_next = finish_hit ? ST_OK : ST_ABSENT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        status_reg    <= status_next;
        present_reg   <= present_next;
        m_status_reg  <= m_status_next;
        m_present_reg <= m_present_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_present     = m_present_reg;
    assign m_entry_count = m_count_reg;

endmodule

@@ src/key_whitelist_table_top.sv @@
// ----------------------------------------------------------------------------
// key_whitelist_table_top
// Table of up to 32 registered 64-bit keys with lookup, add and delete.
// ----------------------------------------------------------------------------
// Each request (lookup, add or delete of one key) yields one result with a
// status, a present flag and the entry count after the request. Requests go
// into a two-entry queue and are executed one at a time. The time from queue
// head to result grows with the number of entries in use; a delete that finds
// its key goes on to walk the entries after it to shift them down. The time is
// set by the single read port of the key RAM, which serves both the match walk
// and the shift-down of a delete. The table needs no clearing pass after
// reset: only read data from slots below the entry count is ever used.
module key_whitelist_table_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kwt_pkg::CMD_W-1:0]          s_command,
    input  logic [kwt_pkg::KEY_W-1:0]          s_key,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kwt_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_present,
    output logic [kwt_pkg::ENTRY_COUNT_W-1:0]  m_entry_count
);
    import kwt_pkg::*;

`include "key_whitelist_table_top_macros.svh"

    logic q_valid;
    req_t q_req;
    logic q_pop;

    kwt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_key     (s_key),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop)
    );

    kwt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_present     (m_present),
        .m_entry_count (m_entry_count)
    );

    // full status only with a full table
    `KWT_ASSERT_IMPL(a_full_count, aclk, aresetn, m_valid && (m_status == ST_FULL), m_entry_count == ENTRY_COUNT_W'(CAPACITY))
    // not-present status never comes with a match
    `KWT_ASSERT_IMPL(a_absent_flag, aclk, aresetn, m_valid && (m_status == ST_ABSENT), !m_present)
    // a popped request leaves room in the queue next cycle
    `KWT_ASSERT_NEXT(a_pop_frees, aclk, aresetn, q_pop, s_ready)

endmodule

@@ sim/key_whitelist_table_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_whitelist_table_top_test
// Self-checking bench: lookup, add and delete requests against a local table.
// ----------------------------------------------------------------------------
// Every accepted request is applied to a local copy of the key table and the
// entry count, and the result it must produce is queued. Each result taken
// from the block is checked field by field against the oldest queued one.
// Both sides idle in random bursts. One phase holds the result side off for a
// long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module key_whitelist_table_top_test;
    import kwt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;   // acts as lookup
    localparam logic [KEY_W-1:0] ERASED_KEY   = {KEY_W{1'b1}};
    localparam int               LONG_HOLD    = 300;
    localparam int               POOL_SIZE    = 16;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     present;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } table_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command;
    logic [KEY_W-1:0]         s_key;
    logic                     m_valid;
    logic                     m_ready;
    logic [STATUS_W-1:0]      m_status;
    logic                     m_present;
    logic [ENTRY_COUNT_W-1:0] m_entry_count;

    // local copy of the table
    logic [KEY_W-1:0] table_keys [CAPACITY];
    int               table_count;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    table_result_t pending_results[$];
    int            mismatch_count = 0;
    bit            idle_en        = 1'b1;
    bit            hold_long      = 1'b0;

    key_whitelist_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_present     (m_present),
        .m_entry_count (m_entry_count)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Apply one request to the local table and return the result it yields.
    function automatic table_result_t apply_to_table(logic [CMD_W-1:0] cmd,
                                                     logic [KEY_W-1:0] key);
        table_result_t res;
        int            pos;
        bit            hit;
        pos = -1;
        for (int i = 0; i < table_count; i++) begin
            if (pos < 0 && table_keys[i] == key) begin
                pos = i;
            end
        end
        hit = (pos >= 0);
        if (cmd == CMD_ADD) begin
            if (table_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                table_keys[table_count] = key;
                table_count++;
                res.status = ST_OK;
            end
        end else if (cmd == CMD_DELETE) begin
            if (!hit) begin
                res.status = ST_ABSENT;
            end else begin
                for (int i = pos; i + 1 < CAPACITY; i++) begin
                    table_keys[i] = table_keys[i + 1];
                end
                table_count--;
                for (int i = table_count; i < CAPACITY; i++) begin
                    table_keys[i] = ERASED_KEY;
                end
                res.status = ST_OK;
            end
        end else begin
            res.status = hit ? ST_OK : ST_ABSENT;
        end
        res.present     = hit;
        res.entry_count = table_count[ENTRY_COUNT_W-1:0];
        return res;
    endfunction

    // Mostly keys in use or recently seen, so that hits and duplicates are common.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && table_count > 0) begin
            return table_keys[$urandom_range(0, table_count - 1)];
        end
        if (r < 80) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        if (r < 85) begin
            return ERASED_KEY;
        end
        if (r < 88) begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    // Offer one request; returns at the edge where it is accepted.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_to_table(cmd, key));
    endtask

    task automatic run_random(input int n, input int add_pct, input int del_pct);
        logic [CMD_W-1:0] cmd;
        int               r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                cmd = CMD_ADD;
            end else if (r < add_pct + del_pct) begin
                cmd = CMD_DELETE;
            end else if (r < add_pct + del_pct + 5) begin
                cmd = CMD_RESERVED;
            end else begin
                cmd = CMD_LOOKUP;
            end
            if ($urandom_range(0, 19) == 0) begin
                key_pool[$urandom_range(2, POOL_SIZE - 1)] = {$urandom, $urandom};
            end
            send_request(cmd, pick_key());
        end
    endtask

    task automatic test_empty_table();
        send_request(CMD_LOOKUP, '0);
        send_request(CMD_DELETE, '0);
        send_request(CMD_LOOKUP, ERASED_KEY);     // erased slots never match
        send_request(CMD_DELETE, ERASED_KEY);
        send_request(CMD_RESERVED, ERASED_KEY);
    endtask

    task automatic test_extreme_keys();
        send_request(CMD_ADD, '0);
        send_request(CMD_ADD, ERASED_KEY);
        send_request(CMD_ADD, '0);                 // duplicate is appended
        send_request(CMD_ADD, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(CMD_ADD, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(CMD_LOOKUP, ERASED_KEY);
        send_request(CMD_RESERVED, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(CMD_DELETE, '0);              // first match goes, copy stays
        send_request(CMD_LOOKUP, '0);
        send_request(CMD_DELETE, 64'h0123_4567_89AB_CDEF);
        send_request(CMD_DELETE, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(CMD_DELETE, ERASED_KEY);
        send_request(CMD_LOOKUP, ERASED_KEY);
        send_request(CMD_DELETE, '0);
        send_request(CMD_DELETE, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(CMD_LOOKUP, 64'hA5A5_A5A5_A5A5_A5A5);
    endtask

    task automatic test_full_table();
        while (table_count < CAPACITY) begin
            send_request(CMD_ADD, ($urandom_range(0, 3) == 0) ? pick_key()
                                                               : {$urandom, $urandom});
        end
        send_request(CMD_ADD, table_keys[CAPACITY - 1]);   // full, key present
        send_request(CMD_ADD, {$urandom, $urandom});        // full, key absent
        send_request(CMD_LOOKUP, table_keys[0]);
        send_request(CMD_DELETE, table_keys[CAPACITY / 2]);
        send_request(CMD_ADD, ERASED_KEY);
        send_request(CMD_DELETE, table_keys[CAPACITY - 1]);
        send_request(CMD_DELETE, table_keys[0]);
    endtask

    task automatic test_drain();
        while (table_count > 0) begin
            send_request(CMD_DELETE, table_keys[$urandom_range(0, table_count - 1)]);
        end
        send_request(CMD_LOOKUP, ERASED_KEY);
        send_request(CMD_DELETE, ERASED_KEY);
    endtask

    task automatic test_output_stall();
        hold_long = 1'b1;
        run_random(24, 40, 20);
    endtask

    task automatic test_random_mix();
        run_random(150, 70, 10);    // grows toward full
        run_random(150, 15, 60);    // shrinks toward empty
        run_random(100, 35, 30);
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        run_random(150, 40, 35);
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_long = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status=%0d present=%0d count=%0d",
                       m_status, m_present, m_entry_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    mismatch_count++;
                end
                if (m_present !== want.present) begin
                    $error("present: expected %0d, actual %0d", want.present, m_present);
                    mismatch_count++;
                end
                if (m_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, m_entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_command = CMD_LOOKUP;
        s_key     = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            table_keys[i] = ERASED_KEY;
        end
        table_count = 0;
        key_pool[0] = '0;
        key_pool[1] = ERASED_KEY;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_extreme_keys();
        test_full_table();
        test_drain();
        test_random_mix();
        test_output_stall();
        test_back_to_back();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/kwt_pkg.sv
src/kwt_ram.sv
src/kwt_front.sv
src/kwt_back.sv
src/key_whitelist_table_top.sv
sim/key_whitelist_table_top_test.sv
